// ===== src/sbc_pkg.sv =====
`default_nettype none

package sbc_pkg;

  localparam int CODE_W   = 3;
  localparam int PAIRS    = 6;
  localparam int CODES_W  = CODE_W * PAIRS;
  localparam int DUTY_W   = 7;
  localparam int CMP_W    = 17;
  localparam int PERIOD_W = 16;
  localparam int PROD_W   = 23;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 30;

  // ceil(2^30 / 100): exact floor(x / 100) for x below 2^30 / 76
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
  localparam logic [DUTY_W-1:0]  DUTY_MAX  = 7'd100;

  localparam logic [1:0] STAGE_STARTUP = 2'd0;
  localparam logic [1:0] STAGE_ALIGN   = 2'd1;
  localparam logic [1:0] STAGE_RUN     = 2'd2;

  localparam logic [2:0] REG_STEP_DELAY = 3'd0;
  localparam logic [2:0] REG_START_DUTY = 3'd1;
  localparam logic [2:0] REG_ALIGN_DUTY = 3'd2;
  localparam logic [2:0] REG_RUN_DUTY   = 3'd3;
  localparam logic [2:0] REG_TOUR       = 3'd4;
  localparam logic [2:0] REG_ALIGN_MULT = 3'd5;
  localparam logic [2:0] REG_PAIR_CODES = 3'd6;
  localparam logic [2:0] REG_PERIOD     = 3'd7;

  localparam logic [2:0] LAST_PAIR = 3'd5;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  typedef logic [CMP_W-1:0] cmp_t;

  function automatic logic [CODE_W-1:0] code_of(input logic [CODES_W-1:0] codes,
                                                 input logic [2:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      3'd0:    c = codes[2:0];
      3'd1:    c = codes[5:3];
      3'd2:    c = codes[8:6];
      3'd3:    c = codes[11:9];
      3'd4:    c = codes[14:12];
      3'd5:    c = codes[17:15];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] hi_of(input logic [2:0] idx);
    logic [1:0] p;
    case (idx)
      3'd0, 3'd1: p = PH_A;
      3'd2, 3'd3: p = PH_B;
      default:    p = PH_C;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] lo_of(input logic [2:0] idx);
    logic [1:0] p;
    case (idx)
      3'd0, 3'd5: p = PH_B;
      3'd1, 3'd2: p = PH_C;
      default:    p = PH_A;
    endcase
    return p;
  endfunction

  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
    return (d > DUTY_MAX) ? DUTY_MAX : d;
  endfunction

  function automatic logic [2:0] next_pair(input logic [2:0] idx);
    return (idx == LAST_PAIR) ? 3'd0 : idx + 3'd1;
  endfunction

endpackage

`default_nettype wire

// ===== src/six_step_bldc_commutator.sv =====
// Each word passes the input register, the commutation/product stage and
// the divide-by-100 reciprocal stage feeding the result register.
// One word per cycle while out_ready does not stall the output.
// in_ready falls only when all three stages hold words and out_ready is low.
// Reset (rst, synchronous): config to defaults, start-up stage, pair 0,
// counters and all compare values to zero, pipeline empty.
`default_nettype none

module six_step_bldc_commutator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [sbc_pkg::CODES_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic                          comp_a,
  input  wire logic                          comp_b,
  input  wire logic                          comp_c,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [16:0]                        high_a,
  output logic [16:0]                        high_b,
  output logic [16:0]                        high_c,
  output logic [16:0]                        low_a,
  output logic [16:0]                        low_b,
  output logic [16:0]                        low_c,
  output logic [15:0]                        center_cmp,
  output logic [1:0]                         stage,
  output logic [2:0]                         pair_index,
  output logic                               drive_updated
);
  import sbc_pkg::*;

  // config
  logic [15:0]         step_delay;
  logic [DUTY_W-1:0]   startup_duty;
  logic [DUTY_W-1:0]   align_duty;
  logic [DUTY_W-1:0]   run_duty;
  logic [7:0]          tour_count;
  logic [7:0]          align_mult;
  logic [CODES_W-1:0]  pair_codes;
  logic [PERIOD_W-1:0] pwm_period;

  // control state
  logic [1:0]  cur_stage, cur_stage_next;
  logic [2:0]  step_index, step_index_next;
  logic [15:0] tick_counter, tick_counter_next;
  logic [7:0]  startup_turns, startup_turns_next;
  logic [15:0] align_turns, align_turns_next;

  // input register
  logic v1, kind1, ca1, cb1, cc1;

  // mid register
  logic              v2, drv2, upd2;
  logic [2:0]        pair2, step2;
  logic [1:0]        stage2;
  logic [CMP_W-1:0]  full2;
  logic [PROD_W-1:0] prod2;

  // handshake
  logic adv_out, ready2, load1, load2, load_out;

  // stage 1 combinational
  logic              drv_en;
  logic [2:0]        drv_pair;
  logic [DUTY_W-1:0] drv_duty;
  logic [CMP_W-1:0]  full;
  logic [15:0]       limit, turns_cur;
  logic [2:0]        rotor, nxt;
  logic              is_last;

  // stage 2 combinational
  logic [PROD_W+RECIP_W-1:0] recip;
  cmp_t                      sig;
  logic [1:0]                hi_p, lo_p;

  assign adv_out  = !out_valid || out_ready;
  assign ready2   = !v2 || adv_out;
  assign in_ready = !v1 || ready2;
  assign load1    = in_valid && in_ready;
  assign load2    = v1 && ready2;
  assign load_out = v2 && adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay   <= 16'd1;
      startup_duty <= 7'd50;
      align_duty   <= 7'd50;
      run_duty     <= 7'd40;
      tour_count   <= 8'd3;
      align_mult   <= 8'd2;
      pair_codes   <= 18'd183449;
      pwm_period   <= 16'd999;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_DELAY: step_delay   <= cfg_data[15:0];
        REG_START_DUTY: startup_duty <= cfg_data[DUTY_W-1:0];
        REG_ALIGN_DUTY: align_duty   <= cfg_data[DUTY_W-1:0];
        REG_RUN_DUTY:   run_duty     <= cfg_data[DUTY_W-1:0];
        REG_TOUR:       tour_count   <= cfg_data[7:0];
        REG_ALIGN_MULT: align_mult   <= cfg_data[7:0];
        REG_PAIR_CODES: pair_codes   <= cfg_data;
        REG_PERIOD:     pwm_period   <= cfg_data[15:0];
      endcase
    end
  end

  // commutation decision on the word in the input register
  always_comb begin
    cur_stage_next     = cur_stage;
    step_index_next    = step_index;
    tick_counter_next  = tick_counter;
    startup_turns_next = startup_turns;
    align_turns_next   = align_turns;
    drv_en             = 1'b0;
    drv_pair           = step_index;
    drv_duty           = '0;
    rotor              = {cc1, cb1, ca1};
    nxt                = next_pair(step_index);
    is_last            = code_of(pair_codes, step_index) == code_of(pair_codes, LAST_PAIR);
    turns_cur          = (cur_stage == STAGE_STARTUP) ? {8'd0, startup_turns} : align_turns;
    limit              = (cur_stage == STAGE_STARTUP) ? {8'd0, tour_count}
                                                      : {8'd0, tour_count} * {8'd0, align_mult};
    if (kind1) begin
      // stop: pair 5 at zero duty leaves only B low active
      drv_en          = 1'b1;
      drv_pair        = LAST_PAIR;
      cur_stage_next  = STAGE_STARTUP;
    end else begin
      unique case (cur_stage) inside
        STAGE_STARTUP, STAGE_ALIGN: begin
          if (tick_counter < step_delay) begin
            tick_counter_next = tick_counter + 16'd1;
          end else begin
            tick_counter_next = '0;
            drv_en            = 1'b1;
            drv_duty          = (cur_stage == STAGE_STARTUP) ? startup_duty : align_duty;
            step_index_next   = nxt;
            if (is_last) begin
              if (turns_cur >= limit) begin
                cur_stage_next  = cur_stage + 2'd1;
                step_index_next = step_index;
                turns_cur       = '0;
              end else begin
                turns_cur = turns_cur + 16'd1;
              end
              if (cur_stage == STAGE_STARTUP) begin
                startup_turns_next = turns_cur[7:0];
              end else begin
                align_turns_next = turns_cur;
              end
            end
          end
        end
        STAGE_RUN: begin
          if (rotor == code_of(pair_codes, nxt)) begin
            step_index_next = nxt;
            drv_en          = 1'b1;
            drv_pair        = nxt;
            drv_duty        = run_duty;
          end
        end
        default: ;
      endcase
    end
    full = {1'b0, pwm_period} + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_stage     <= STAGE_STARTUP;
      step_index    <= '0;
      tick_counter  <= '0;
      startup_turns <= '0;
      align_turns   <= '0;
    end else if (load2) begin
      cur_stage     <= cur_stage_next;
      step_index    <= step_index_next;
      tick_counter  <= tick_counter_next;
      startup_turns <= startup_turns_next;
      align_turns   <= align_turns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      kind1 <= kind;
      ca1   <= comp_a;
      cb1   <= comp_b;
      cc1   <= comp_c;
    end
    if (load2) begin
      drv2   <= drv_en;
      upd2   <= drv_en;
      pair2  <= drv_pair;
      stage2 <= cur_stage_next;
      step2  <= step_index_next;
      full2  <= full;
      prod2  <= {{(PROD_W-CMP_W){1'b0}}, full}
                * {{(PROD_W-DUTY_W){1'b0}}, sat_duty(drv_duty)};
    end
  end

  // divide by 100 and place the compare values
  assign recip = prod2 * RECIP_100;
  assign sig   = recip[RECIP_SH +: CMP_W];
  assign hi_p  = hi_of(pair2);
  assign lo_p  = lo_of(pair2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      high_a     <= '0;
      high_b     <= '0;
      high_c     <= '0;
      low_a      <= '0;
      low_b      <= '0;
      low_c      <= '0;
      center_cmp <= '0;
    end else begin
      if (adv_out) out_valid <= v2;
      if (load_out && drv2) begin
        high_a     <= (hi_p == PH_A) ? sig : '0;
        high_b     <= (hi_p == PH_B) ? sig : '0;
        high_c     <= (hi_p == PH_C) ? sig : '0;
        low_a      <= (lo_p == PH_A) ? full2 : '0;
        low_b      <= (lo_p == PH_B) ? full2 : '0;
        low_c      <= (lo_p == PH_C) ? full2 : '0;
        center_cmp <= sig[CMP_W-1:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      stage         <= stage2;
      pair_index    <= step2;
      drive_updated <= upd2;
    end
  end

`ifndef ASSERT_OFF
  a_one_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_updated |-> $onehot({low_a != '0, low_b != '0, low_c != '0}))
    else $error("drive without exactly one active low side");

  a_one_high: assert property (@(posedge clk) disable iff (rst)
    $onehot0({high_a != '0, high_b != '0, high_c != '0}))
    else $error("more than one active high side");

  a_center: assert property (@(posedge clk) disable iff (rst)
    {1'b0, center_cmp} == ((high_a | high_b | high_c) >> 1))
    else $error("pulse center does not match high side");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    load2 && kind1 |=> cur_stage == STAGE_STARTUP)
    else $error("stop did not return to start-up");

  a_run_tick: assert property (@(posedge clk) disable iff (rst)
    cur_stage == STAGE_RUN && $past(cur_stage == STAGE_RUN) |-> $stable(tick_counter))
    else $error("tick counter moved in run");
`endif

endmodule

`default_nettype wire
